@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; included by the top level, the only file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hdl/i2cms_pkg.sv @@
// shared types and constants of the i2c master byte sequencer
// no dependencies; imported by the front end, sequencer and top level
`default_nettype none

package i2cms_pkg;

	// command held by the sequencer, idle when none runs
	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// mode codes on the request port
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_STOP  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// pin word bits: sda, scl, sda enable
	localparam logic [2:0] PIN_NONE = 3'b000;
	localparam logic [2:0] PIN_SDA  = 3'b001;
	localparam logic [2:0] PIN_SCL  = 3'b010;
	localparam logic [2:0] PIN_OE   = 3'b100;
	localparam logic [2:0] PIN_ALL  = 3'b111;

	// register map
	localparam logic       REG_PHASE_LENGTH   = 1'b0;
	localparam logic [7:0] PHASE_LENGTH_RESET = 8'd5;

	// classified request from the front end
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wr_data;
		logic       rd_ack;
		logic       sda_line;
	} req_t;

	// one result per tick
	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_oe;
		logic       busy;
		logic       done;
		logic [7:0] rd_data;
		logic       ack_error;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/i2c_master_byte_sequencer.sv @@
// top level of the i2c master byte sequencer: queues, sequencer and register port
// depends on i2cms_pkg, i2cms_front, i2cms_seq, i2cms_fifo and assert_macros.svh
//
// Each request is one tick of a bit-bang i2c master: an optional command (start,
// stop, write byte with ack check, read byte with ack or nack) plus the sampled
// sda level. Every request yields exactly one result holding the driven scl,
// sda and sda enable, busy, done, the last read byte and the ack error flag.
// Each pin word is held phase_length ticks (register 0 at byte address 0,
// reset 5, zero acts as one). Requests are taken one per clock while the request
// queue is not full; the sequencer advances one tick per cycle while a request waits
// and the result queue has room. A result is registered in the result queue,
// whose head drives the result ports; back-to-back pushes with the result side
// popping give one result per cycle. The request and result queues hold QUEUE_DEPTH
// entries each, so either side may stall without the other. Commands offered while
// a sequence runs are dropped; a stop on an already released bus finishes in its
// own tick; a write without acknowledge appends a stop and sets ack_error.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_byte_sequencer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  logic        cmd_valid,
	input  logic [1:0]  mode,
	input  logic [7:0]  wr_data,
	input  logic        rd_ack,
	input  logic        sda_line,
	// result side
	input  logic        pop,
	output logic        empty,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_oe,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rd_data,
	output logic        ack_error,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import i2cms_pkg::*;

	logic [7:0] phase_length_q;
	req_t       seq_req;
	logic       req_empty;
	logic       req_pop;
	res_t       seq_res;
	res_t       out_res;
	logic       res_push;
	logic       res_full;
	logic       cfg_wr;
	logic       busy_push;
	logic       keeps_on;

	// register port, always ready; only bit 2 of the address selects a register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_PHASE_LENGTH) ? {24'b0, phase_length_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_length_q <= PHASE_LENGTH_RESET;
		end else if (cfg_wr && paddr[2] == REG_PHASE_LENGTH) begin
			phase_length_q <= pwdata[7:0];
		end
	end

	// front: decode and queue requests
	i2cms_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd_valid(cmd_valid),
		.mode     (mode),
		.wr_data  (wr_data),
		.rd_ack   (rd_ack),
		.sda_line (sda_line),
		.pop      (req_pop),
		.req      (seq_req),
		.empty    (req_empty)
	);

	// back: one sequencer tick per request
	i2cms_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_length(phase_length_q),
		.in_empty    (req_empty),
		.in_req      (seq_req),
		.in_pop      (req_pop),
		.out_full    (res_full),
		.out_push    (res_push),
		.out_res     (seq_res)
	);

	// result queue parts the sequencer from the consumer
	i2cms_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH($bits(res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (seq_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign scl       = out_res.scl;
	assign sda_out   = out_res.sda_out;
	assign sda_oe    = out_res.sda_oe;
	assign busy_res  = out_res.busy;
	assign done_res  = out_res.done;
	assign rd_data   = out_res.rd_data;
	assign ack_error = out_res.ack_error;

	// sequencer tick that leaves a sequence running, and a tick that continues or ends one
	assign busy_push = res_push && seq_res.busy;
	assign keeps_on  = seq_res.busy || seq_res.done;

	// a finishing tick never reports busy
	`ASSERT_NEVER(a_done_not_busy, clk, arst_n, !empty && done_res && busy_res, "done while busy")
	// a running sequence either keeps going or reports done on the next tick
	`ASSERT_CLK(a_busy_continues, clk, arst_n, res_push && $past(busy_push) |-> keeps_on, "busy dropped")

endmodule

`default_nettype wire

@@ hdl/i2cms_fifo.sv @@
// small first-in first-out queue with push/full and pop/empty sides
// no dependencies; used for the request and result queues
`default_nettype none

module i2cms_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/i2cms_front.sv @@
// front end: takes ticks, decodes the command and queues the request
// depends on i2cms_pkg and i2cms_fifo
`default_nettype none

module i2cms_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              cmd_valid,
	input  logic [1:0]        mode,
	input  logic [7:0]        wr_data,
	input  logic              rd_ack,
	input  logic              sda_line,
	input  logic              pop,
	output i2cms_pkg::req_t   req,
	output logic              empty
);

	import i2cms_pkg::*;

	req_t req_in;

	// no offer means an idle tick
	always_comb begin
		req_in.wr_data  = wr_data;
		req_in.rd_ack   = rd_ack;
		req_in.sda_line = sda_line;
		if (!cmd_valid) begin
			req_in.cmd = CMD_IDLE;
		end else begin
			case (mode)
				MODE_START: req_in.cmd = CMD_START;
				MODE_STOP:  req_in.cmd = CMD_STOP;
				MODE_WRITE: req_in.cmd = CMD_WRITE;
				default:    req_in.cmd = CMD_READ;
			endcase
		end
	end

	i2cms_fifo #(
		.DEPTH(DEPTH),
		.WIDTH($bits(req_t))
	) u_req_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (req_in),
		.full  (full),
		.pop   (pop),
		.rdata (req),
		.empty (empty)
	);

endmodule

`default_nettype wire

@@ hdl/i2cms_seq.sv @@
// back end: phase sequencer that turns one request per tick into one result
// depends on i2cms_pkg
`default_nettype none

module i2cms_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      phase_length,
	input  logic            in_empty,
	input  i2cms_pkg::req_t in_req,
	output logic            in_pop,
	input  logic            out_full,
	output logic            out_push,
	output i2cms_pkg::res_t out_res
);

	import i2cms_pkg::*;

	localparam logic [4:0] WR_BIT_STEPS = 5'd24;
	localparam logic [4:0] WR_ACK_STEP  = 5'd25;
	localparam logic [4:0] RD_BIT_STEPS = 5'd16;

	cmd_t       act_q, act_d;
	logic [4:0] step_q, step_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] hold_q, hold_d;
	logic [2:0] pin_q, pin_d;
	logic       ackr_q, ackr_d;
	logic       err_q, err_d;
	logic [7:0] rdb_q, rdb_d;
	logic       done;
	logic [7:0] hold_init;
	logic [2:0] rd_bit;

	// last step index of each sequence
	function automatic logic [4:0] last_step(cmd_t c, logic err, logic ack);
		logic [4:0] l;
		case (c)
			CMD_START: l = 5'd1;
			CMD_STOP:  l = 5'd1;
			CMD_WRITE: l = err ? 5'd28 : 5'd26;
			CMD_READ:  l = ack ? 5'd18 : 5'd19;
			default:   l = 5'd0;
		endcase
		return l;
	endfunction

	// pin word shown at step s of a sequence
	function automatic logic [2:0] word_at(cmd_t c, logic [4:0] s, logic [7:0] sb,
		logic ack);
		logic [7:0] k8;
		logic [2:0] k;
		logic [1:0] r;
		logic       cur;
		logic       prev;
		logic [2:0] w;
		// s / 3 for s below 24 by reciprocal multiply
		k8   = 8'(s) * 8'd11;
		k    = k8[7:5];
		r    = 2'(s - 5'(k) * 5'd3);
		cur  = sb[~k];
		prev = (k == 3'd0) ? 1'b0 : sb[3'(~k + 3'd1)];
		case (c)
			CMD_START: w = (s == 5'd0) ? PIN_ALL : (PIN_SCL | PIN_OE);
			CMD_STOP:  w = (s == 5'd0) ? (PIN_SCL | PIN_OE) : PIN_ALL;
			CMD_WRITE: begin
				if (s < WR_BIT_STEPS) begin
					case (r)
						2'd0:    w = PIN_OE | {2'b00, prev};
						2'd1:    w = PIN_OE | {2'b00, cur};
						default: w = PIN_OE | PIN_SCL | {2'b00, cur};
					endcase
				end else begin
					case (s)
						5'd24:   w = {2'b00, sb[0]};
						5'd25:   w = PIN_SCL;
						5'd26:   w = PIN_NONE;
						5'd27:   w = PIN_SCL | PIN_OE;
						default: w = PIN_ALL;
					endcase
				end
			end
			CMD_READ: begin
				if (s < RD_BIT_STEPS) begin
					w = s[0] ? {2'b00, sb[~s[3:1]]} : PIN_SCL;
				end else if (ack) begin
					case (s)
						5'd16:   w = PIN_OE;
						5'd17:   w = PIN_SCL | PIN_OE;
						default: w = PIN_NONE;
					endcase
				end else begin
					case (s)
						5'd16:   w = PIN_OE;
						5'd17:   w = PIN_OE | PIN_SDA;
						5'd18:   w = PIN_ALL;
						default: w = PIN_NONE;
					endcase
				end
			end
			default: w = PIN_ALL;
		endcase
		return w;
	endfunction

	assign in_pop    = !in_empty && !out_full;
	assign out_push  = in_pop;
	assign hold_init = (phase_length == 8'd0) ? 8'd1 : phase_length;
	assign rd_bit    = ~step_q[3:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= CMD_IDLE;
			step_q  <= '0;
			shift_q <= '0;
			hold_q  <= '0;
			pin_q   <= PIN_ALL;
			ackr_q  <= 1'b0;
			err_q   <= 1'b0;
			rdb_q   <= '0;
		end else begin
			act_q   <= act_d;
			step_q  <= step_d;
			shift_q <= shift_d;
			hold_q  <= hold_d;
			pin_q   <= pin_d;
			ackr_q  <= ackr_d;
			err_q   <= err_d;
			rdb_q   <= rdb_d;
		end
	end

	always_comb begin
		act_d   = act_q;
		step_d  = step_q;
		shift_d = shift_q;
		hold_d  = hold_q;
		pin_d   = pin_q;
		ackr_d  = ackr_q;
		err_d   = err_q;
		rdb_d   = rdb_q;
		done    = 1'b0;
		if (in_pop) begin
			if (act_q == CMD_IDLE) begin
				// first word of each command is fixed
				case (in_req.cmd)
					CMD_START: begin
						act_d  = CMD_START;
						pin_d  = PIN_ALL;
						step_d = '0;
						hold_d = hold_init;
					end
					CMD_STOP: begin
						if (pin_q == PIN_ALL) begin
							done = 1'b1;
						end else begin
							act_d  = CMD_STOP;
							pin_d  = PIN_SCL | PIN_OE;
							step_d = '0;
							hold_d = hold_init;
						end
					end
					CMD_WRITE: begin
						act_d   = CMD_WRITE;
						shift_d = in_req.wr_data;
						pin_d   = PIN_OE;
						step_d  = '0;
						hold_d  = hold_init;
					end
					CMD_READ: begin
						act_d   = CMD_READ;
						shift_d = '0;
						ackr_d  = in_req.rd_ack;
						pin_d   = PIN_SCL;
						step_d  = '0;
						hold_d  = hold_init;
					end
					default: ;
				endcase
			end else if (hold_q > 8'd1) begin
				hold_d = hold_q - 8'd1;
			end else begin
				// end of a word: sample, then finish or load next word
				if (act_q == CMD_WRITE && step_q == WR_ACK_STEP) begin
					err_d = in_req.sda_line;
				end
				if (act_q == CMD_READ && step_q < RD_BIT_STEPS && !step_q[0]) begin
					shift_d[rd_bit] = shift_q[rd_bit] | in_req.sda_line;
				end
				if (step_q >= last_step(act_q, err_d, ackr_q)) begin
					if (act_q == CMD_READ) begin
						rdb_d = shift_d;
					end
					act_d  = CMD_IDLE;
					step_d = '0;
					hold_d = '0;
					done   = 1'b1;
				end else begin
					step_d = step_q + 5'd1;
					pin_d  = word_at(act_q, step_d, shift_d, ackr_q);
					hold_d = hold_init;
				end
			end
		end
	end

	always_comb begin
		out_res.scl       = pin_d[1];
		out_res.sda_out   = pin_d[0];
		out_res.sda_oe    = pin_d[2];
		out_res.busy      = (act_d != CMD_IDLE);
		out_res.done      = done;
		out_res.rd_data   = rdb_d;
		out_res.ack_error = err_d;
	end

endmodule

`default_nettype wire
